FILE: rtl/core/piecewise_linear_interp_table_macros.svh
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_MACROS_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define PLIT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plit assertion failed");

// next-cycle implication on clk, held off during reset
`define PLIT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plit assertion failed");

`endif

FILE: rtl/core/plit_pkg.sv
package plit_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_SCALE = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_DIV0  = 2'd2,
		STS_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_OVERWRITE,
		CELL_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic signed [31:0] key_x;
		logic signed [31:0] new_y;
	} cell_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_APPLY,
		ST_MUL,
		ST_QDIV,
		ST_QWAIT,
		ST_RDIV,
		ST_RWAIT,
		ST_SETTLE,
		ST_DONE
	} state_t;

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

endpackage

FILE: rtl/core/plit_cell.sv
module plit_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  plit_pkg::cell_ctrl_t ctrl,
	input  logic                valid,
	input  logic                left_lt,
	input  logic signed [31:0]  left_x,
	input  logic signed [31:0]  left_y,
	input  logic [30:0]         left_max,
	output logic signed [31:0]  x,
	output logic signed [31:0]  y,
	output logic                lt,
	output logic                eq,
	output logic [30:0]         max
);

	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [30:0]        max_q;
	logic [31:0]        neg_y;
	logic [30:0]        mag;
	logic [30:0]        own;

	assign lt    = valid && (x_q < ctrl.key_x);
	assign eq    = valid && (x_q == ctrl.key_x);
	assign neg_y = -y_q;
	assign mag   = (y_q == 32'sh8000_0000) ? plit_pkg::MAG_MAX :
		(y_q[31] ? neg_y[30:0] : y_q[30:0]);
	assign own   = valid ? mag : 31'd0;

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			plit_pkg::CELL_INSERT: begin
				if (!lt) begin
					if (left_lt) begin
						x_q <= ctrl.key_x;
						y_q <= ctrl.new_y;
					end else begin
						x_q <= left_x;
						y_q <= left_y;
					end
				end
			end
			plit_pkg::CELL_OVERWRITE: begin
				if (eq) y_q <= ctrl.new_y;
			end
			plit_pkg::CELL_ROTATE: begin
				y_q <= left_y;
			end
			plit_pkg::CELL_HOLD: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= '0;
		else max_q <= (own > left_max) ? own : left_max;
	end

	assign x   = x_q;
	assign y   = y_q;
	assign max = max_q;

endmodule

FILE: rtl/core/plit_div.sv
module plit_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, dvd_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				dvd_q <= {dvd_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dvd_q[63]};
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: rtl/core/piecewise_linear_interp_table.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | req_type, key_x, operand_y
// out     | out_valid / out_stall| result_value, largest_magnitude, status
//
// Load, query miss and no-op: the time is set by the magnitude chain settling.
// Interpolating query: multiply, divide in the shared divider, then settle the chain.
// Scale: y rotates through the divider one cell per division, then the chain settles.
// Reset empties the table at once; no clearing pass.
// A result waiting on out_stall holds only the final step; requests wait in_stall.
module piecewise_linear_interp_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] operand_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [30:0]        largest_magnitude,
	output logic [1:0]         status
);

`include "piecewise_linear_interp_table_macros.svh"

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = $clog2(TABLE_DEPTH);

	plit_pkg::state_t     state_q, state_d;
	plit_pkg::cell_ctrl_t ctrl;
	plit_pkg::cell_cmd_t  cmd;

	logic [CW-1:0] count_q;
	logic [RW-1:0] rot_q;
	logic [CW-1:0] set_q;
	logic          out_valid_q;
	logic          out_free;

	logic [1:0]         req_q;
	logic signed [31:0] key_q;
	logic signed [31:0] oy_q;
	logic signed [31:0] res_q;
	logic [1:0]         st_q;
	logic               have_a_q, have_b_q, eqb_q;
	logic signed [31:0] xa_q, ya_q, xb_q, yb_q;
	logic [63:0]        prod_q;
	logic               qneg_q, rneg_q;
	logic signed [31:0] res_out_q;
	logic [30:0]        mag_out_q;
	logic [1:0]         sts_out_q;

	logic signed [31:0] cx [TABLE_DEPTH];
	logic signed [31:0] cy [TABLE_DEPTH];
	logic               clt [TABLE_DEPTH];
	logic               ceq [TABLE_DEPTH];
	logic               cval [TABLE_DEPTH];
	logic               plt [TABLE_DEPTH];
	logic               nlt [TABLE_DEPTH];
	logic [30:0]        cmax [TABLE_DEPTH];

	logic               have_a, have_b, eqb;
	logic signed [31:0] xa, ya, xb, yb;

	logic        div_start, div_busy, div_done;
	logic [63:0] div_dvd, div_q;
	logic [31:0] div_dvs;

	logic [32:0] dd;
	logic [31:0] absd, tt, dx, ylast_abs, oy_abs, neg_q32;
	logic signed [31:0] rot_y;
	logic        eq_hit, can_ins;

	assign eq_hit  = have_b_q && eqb_q;
	assign can_ins = !eq_hit && (count_q != CW'(TABLE_DEPTH));

	assign ctrl.cmd   = cmd;
	assign ctrl.key_x = key_q;
	assign ctrl.new_y = oy_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic               l_lt;
		logic signed [31:0] l_x, l_y;
		logic [30:0]        l_max;

		assign cval[i] = count_q > CW'(i);

		if (i == 0) begin : g_head
			assign l_lt   = 1'b1;
			assign l_x    = key_q;
			assign l_y    = rot_y;
			assign l_max  = '0;
			assign plt[i] = 1'b1;
		end else begin : g_body
			assign l_lt   = clt[i-1];
			assign l_x    = cx[i-1];
			assign l_y    = cy[i-1];
			assign l_max  = cmax[i-1];
			assign plt[i] = clt[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nlt[i] = 1'b0;
		end else begin : g_next
			assign nlt[i] = clt[i+1];
		end

		plit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.valid    (cval[i]),
			.left_lt  (l_lt),
			.left_x   (l_x),
			.left_y   (l_y),
			.left_max (l_max),
			.x        (cx[i]),
			.y        (cy[i]),
			.lt       (clt[i]),
			.eq       (ceq[i]),
			.max      (cmax[i])
		);
	end

	always_comb begin
		have_a = 1'b0;
		have_b = 1'b0;
		eqb    = 1'b0;
		xa     = '0;
		ya     = '0;
		xb     = '0;
		yb     = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (clt[i] && !nlt[i]) begin
				have_a = 1'b1;
				xa     = xa | cx[i];
				ya     = ya | cy[i];
			end
			if (cval[i] && !clt[i] && plt[i]) begin
				have_b = 1'b1;
				eqb    = eqb | ceq[i];
				xb     = xb | cx[i];
				yb     = yb | cy[i];
			end
		end
	end

	assign dd        = {yb_q[31], yb_q} - {ya_q[31], ya_q};
	assign absd      = dd[32] ? 32'(-dd) : dd[31:0];
	assign tt        = 32'(key_q - xa_q);
	assign dx        = 32'(xb_q - xa_q);
	assign ylast_abs = cy[TABLE_DEPTH-1][31] ? 32'(-cy[TABLE_DEPTH-1]) : cy[TABLE_DEPTH-1];
	assign oy_abs    = oy_q[31] ? 32'(-oy_q) : oy_q;
	assign neg_q32   = -div_q[31:0];

	always_comb begin
		if (rneg_q) begin
			rot_y = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : neg_q32;
		end else begin
			rot_y = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
		end
	end

	plit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plit_pkg::ST_IDLE:  if (in_valid) state_d = plit_pkg::ST_LOOK;
			plit_pkg::ST_LOOK:  state_d = plit_pkg::ST_APPLY;
			plit_pkg::ST_APPLY: begin
				state_d = plit_pkg::ST_SETTLE;
				if (req_q == plit_pkg::REQ_QUERY && count_q != '0 && have_a_q && have_b_q
					&& !eqb_q)
					state_d = plit_pkg::ST_MUL;
				if (req_q == plit_pkg::REQ_SCALE && oy_q != '0 && count_q != '0)
					state_d = plit_pkg::ST_RDIV;
			end
			plit_pkg::ST_MUL:   state_d = plit_pkg::ST_QDIV;
			plit_pkg::ST_QDIV:  state_d = plit_pkg::ST_QWAIT;
			plit_pkg::ST_QWAIT: if (div_done) state_d = plit_pkg::ST_SETTLE;
			plit_pkg::ST_RDIV:  state_d = plit_pkg::ST_RWAIT;
			plit_pkg::ST_RWAIT: begin
				if (div_done) begin
					state_d = (rot_q == RW'(TABLE_DEPTH - 1)) ? plit_pkg::ST_SETTLE :
						plit_pkg::ST_RDIV;
				end
			end
			plit_pkg::ST_SETTLE: if (set_q == CW'(TABLE_DEPTH)) state_d = plit_pkg::ST_DONE;
			plit_pkg::ST_DONE:  if (out_free) state_d = plit_pkg::ST_IDLE;
			default:            state_d = plit_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = plit_pkg::CELL_HOLD;
		div_start = 1'b0;
		div_dvd   = {16'd0, ylast_abs, 16'd0};
		div_dvs   = oy_abs;
		in_stall  = (state_q != plit_pkg::ST_IDLE);
		if (state_q == plit_pkg::ST_APPLY && req_q == plit_pkg::REQ_LOAD) begin
			if (eq_hit) cmd = plit_pkg::CELL_OVERWRITE;
			else if (can_ins) cmd = plit_pkg::CELL_INSERT;
		end
		if (state_q == plit_pkg::ST_RWAIT && div_done) cmd = plit_pkg::CELL_ROTATE;
		if (state_q == plit_pkg::ST_QDIV) begin
			div_start = 1'b1;
			div_dvd   = prod_q;
			div_dvs   = dx;
		end
		if (state_q == plit_pkg::ST_RDIV) div_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plit_pkg::ST_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			set_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plit_pkg::ST_APPLY && req_q == plit_pkg::REQ_LOAD && can_ins)
				count_q <= count_q + CW'(1);
			if (state_q == plit_pkg::ST_APPLY) rot_q <= '0;
			else if (state_q == plit_pkg::ST_RWAIT && div_done) rot_q <= rot_q + RW'(1);
			if (state_q == plit_pkg::ST_SETTLE) set_q <= set_q + CW'(1);
			else set_q <= '0;
			if (state_q == plit_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			plit_pkg::ST_IDLE: begin
				req_q <= req_type;
				key_q <= key_x;
				oy_q  <= operand_y;
				res_q <= '0;
				st_q  <= plit_pkg::STS_OK;
			end
			plit_pkg::ST_LOOK: begin
				have_a_q <= have_a;
				have_b_q <= have_b;
				eqb_q    <= eqb;
				xa_q     <= xa;
				ya_q     <= ya;
				xb_q     <= xb;
				yb_q     <= yb;
			end
			plit_pkg::ST_APPLY: begin
				if (req_q == plit_pkg::REQ_LOAD) begin
					if (!eq_hit && !can_ins) st_q <= plit_pkg::STS_FULL;
				end else if (req_q == plit_pkg::REQ_QUERY) begin
					if (count_q == '0) st_q <= plit_pkg::STS_EMPTY;
					else if (!have_a_q) res_q <= yb_q;
					else if (!have_b_q) res_q <= ya_q;
					else if (eqb_q) res_q <= yb_q;
				end else if (req_q == plit_pkg::REQ_SCALE) begin
					if (oy_q == '0) st_q <= plit_pkg::STS_DIV0;
					else if (count_q == '0) st_q <= plit_pkg::STS_EMPTY;
				end
			end
			plit_pkg::ST_MUL: begin
				prod_q <= 64'(absd) * 64'(tt);
				qneg_q <= dd[32];
			end
			plit_pkg::ST_QWAIT: begin
				if (div_done) res_q <= qneg_q ? ya_q - div_q[31:0] : ya_q + div_q[31:0];
			end
			plit_pkg::ST_RDIV: begin
				rneg_q <= cy[TABLE_DEPTH-1][31] ^ oy_q[31];
			end
			plit_pkg::ST_DONE: begin
				if (out_free) begin
					res_out_q <= res_q;
					mag_out_q <= cmax[TABLE_DEPTH-1];
					sts_out_q <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign result_value      = res_out_q;
	assign largest_magnitude = mag_out_q;
	assign status            = sts_out_q;

	`PLIT_ASSERT_NXT(a_accept_holds_off, in_valid && !in_stall, in_stall)
	`PLIT_ASSERT_IMP(a_count_in_range, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`PLIT_ASSERT_IMP(a_idle_div_quiet, state_q == plit_pkg::ST_IDLE, !div_busy)

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH      = 64;
	localparam int IDLE_LIMIT = 40000;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic signed [31:0] value;
		logic [30:0]        mag;
		plit_pkg::status_t  st;
	} answer_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic signed [31:0] key_x;
	logic signed [31:0] operand_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_value;
	logic [30:0]        largest_magnitude;
	logic [1:0]         status;

	logic signed [31:0] pts_x [DEPTH];
	logic signed [31:0] pts_y [DEPTH];
	int                 n_pts;
	answer_t            answers_due [$];
	int                 errors;
	int                 idle_cycles;
	int                 burst_left;
	bit                 hold_req;

	piecewise_linear_interp_table #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .key_x(key_x), .operand_y(operand_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .largest_magnitude(largest_magnitude),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic int lower_slot(logic signed [31:0] k);
		int i;
		i = 0;
		while (i < n_pts && pts_x[i] < k)
			i++;
		return i;
	endfunction

	function automatic logic [30:0] peak_abs();
		longint best;
		longint y;
		best = 0;
		for (int i = 0; i < n_pts; i++) begin
			y = pts_y[i];
			if (y < 0)
				y = -y;
			if (y > best)
				best = y;
		end
		return (best > 64'sd2147483647) ? plit_pkg::MAG_MAX : best[30:0];
	endfunction

	function automatic answer_t apply_request(logic [1:0] rq, logic signed [31:0] x,
			logic signed [31:0] y);
		answer_t a;
		int i;
		longint x1, x2, y1, y2, d;
		longint unsigned dx, t, m, q;
		a.value = '0;
		a.st = plit_pkg::STS_OK;
		case (rq)
			plit_pkg::REQ_LOAD: begin
				i = lower_slot(x);
				if (i < n_pts && pts_x[i] == x)
					pts_y[i] = y;
				else if (n_pts >= DEPTH)
					a.st = plit_pkg::STS_FULL;
				else begin
					for (int j = n_pts; j > i; j--) begin
						pts_x[j] = pts_x[j-1];
						pts_y[j] = pts_y[j-1];
					end
					pts_x[i] = x;
					pts_y[i] = y;
					n_pts++;
				end
			end
			plit_pkg::REQ_QUERY: begin
				if (n_pts == 0)
					a.st = plit_pkg::STS_EMPTY;
				else begin
					i = lower_slot(x);
					if (i == 0)
						a.value = pts_y[0];
					else if (i >= n_pts)
						a.value = pts_y[n_pts-1];
					else if (pts_x[i] == x)
						a.value = pts_y[i];
					else begin
						x1 = pts_x[i-1];
						y1 = pts_y[i-1];
						x2 = pts_x[i];
						y2 = pts_y[i];
						dx = x2 - x1;
						t = longint'(x) - x1;
						d = y2 - y1;
						m = longint'(d < 0 ? -d : d);
						m = m * t;
						q = m / dx;
						a.value = sat32(d < 0 ? y1 - longint'(q) : y1 + longint'(q));
					end
				end
			end
			plit_pkg::REQ_SCALE: begin
				if (y == 0)
					a.st = plit_pkg::STS_DIV0;
				else if (n_pts == 0)
					a.st = plit_pkg::STS_EMPTY;
				else
					for (int j = 0; j < n_pts; j++)
						pts_y[j] = sat32((longint'(pts_y[j]) * 65536) / longint'(y));
			end
			default: ;
		endcase
		a.mag = peak_abs();
		return a;
	endfunction

	task automatic send_request(plit_pkg::req_t rq, logic signed [31:0] x,
			logic signed [31:0] y);
		@(negedge clk);
		in_valid = 1'b1;
		req_type = rq;
		key_x = x;
		operand_y = y;
		do
			@(posedge clk);
		while (in_stall);
		answers_due.push_back(apply_request(rq, x, y));
		if (burst_left > 0)
			burst_left--;
		else begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
		end
	endtask

	// receiver stall pattern, with a long hold on request
	int stall_mode;
	int mode_left;
	int hold_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			hold_left <= 0;
		end else begin
			if (hold_req && hold_left == 0)
				hold_left <= HOLD_LEN;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 3);
					mode_left <= $urandom_range(50, 600);
				end else
					mode_left <= mode_left - 1;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result value=%0d", result_value);
				errors++;
			end else begin
				a = answers_due.pop_front();
				if (result_value !== a.value) begin
					$error("result_value expected %0d got %0d", a.value, result_value);
					errors++;
				end
				if (largest_magnitude !== a.mag) begin
					$error("largest_magnitude expected %0d got %0d", a.mag,
						largest_magnitude);
					errors++;
				end
				if (status !== a.st) begin
					$error("status expected %0d got %0d", a.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[piecewise_linear_interp_table] ERROR");
				$finish;
			end
		end
	end

	task automatic test_empty_table();
		send_request(plit_pkg::REQ_QUERY, 32'sh0001_0000, 32'sd0);
		send_request(plit_pkg::REQ_SCALE, 32'sd0, 32'sd0);
		send_request(plit_pkg::REQ_SCALE, 32'sd5, 32'sh0002_0000);
		send_request(plit_pkg::REQ_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000);
	endtask

	task automatic test_lookup();
		send_request(plit_pkg::REQ_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_request(plit_pkg::REQ_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_request(plit_pkg::REQ_LOAD, 32'sd0, 32'sh0003_0000);
		send_request(plit_pkg::REQ_LOAD, 32'sh0004_0000, -32'sh0001_8000);
		send_request(plit_pkg::REQ_QUERY, 32'sh8000_0000, 32'sd0);
		send_request(plit_pkg::REQ_QUERY, 32'sh7FFF_FFFF, 32'sd0);
		send_request(plit_pkg::REQ_QUERY, 32'sd0, 32'sd0);
		send_request(plit_pkg::REQ_QUERY, 32'sh0001_2345, 32'sd0);
		send_request(plit_pkg::REQ_QUERY, -32'sh0100_0001, 32'sd0);
		send_request(plit_pkg::REQ_QUERY, 32'sh4000_0000, 32'sd0);
		send_request(plit_pkg::REQ_LOAD, 32'sd0, -32'sh0007_0000);
		send_request(plit_pkg::REQ_QUERY, 32'sh0000_0001, 32'sd0);
		send_request(plit_pkg::REQ_NONE, 32'sd0, 32'sd0);
		send_request(plit_pkg::REQ_SCALE, 32'sd0, 32'sh0001_0000);
		send_request(plit_pkg::REQ_SCALE, 32'sd0, -32'sh0002_0000);
		send_request(plit_pkg::REQ_SCALE, 32'sd0, 32'sd1);
		send_request(plit_pkg::REQ_SCALE, 32'sd0, 32'sd0);
		send_request(plit_pkg::REQ_LOAD, 32'sh7FFF_FFFF, 32'sd0);
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		hold_req = 1'b0;
		burst_left = 12;
		for (int i = 0; i < 10; i++)
			send_request(($urandom_range(0, 1) == 0) ? plit_pkg::REQ_LOAD :
				plit_pkg::REQ_QUERY, $urandom, $urandom);
	endtask

	task automatic test_random(int count);
		int pick, i;
		logic signed [31:0] x, y;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			y = $urandom;
			if (n_pts > 0 && $urandom_range(0, 2) == 0)
				x = pts_x[$urandom_range(0, n_pts - 1)];
			else if ($urandom_range(0, 1) == 0)
				x = $urandom;
			else
				x = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			if (pick < 45) begin
				if ($urandom_range(0, 3) == 0)
					y = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
				send_request(plit_pkg::REQ_LOAD, x, y);
			end else if (pick < 90) begin
				if (n_pts > 1 && $urandom_range(0, 1) == 0) begin
					i = $urandom_range(1, n_pts - 1);
					x = pts_x[i-1] + $signed($urandom_range(0,
						32'(pts_x[i] - pts_x[i-1])));
				end
				send_request(plit_pkg::REQ_QUERY, x, y);
			end else if (pick < 94) begin
				case ($urandom_range(0, 3))
					0: y = 32'sd0;
					1: y = $urandom;
					default: y = $signed($urandom_range(32'h0000_8000, 32'h0003_0000))
						* (($urandom_range(0, 1) == 0) ? 1 : -1);
				endcase
				send_request(plit_pkg::REQ_SCALE, x, y);
			end else
				send_request(plit_pkg::REQ_NONE, x, y);
		end
	endtask

	task automatic test_full_table();
		logic signed [31:0] x;
		while (n_pts < DEPTH) begin
			x = $urandom;
			send_request(plit_pkg::REQ_LOAD, x, $urandom);
		end
		x = $urandom;
		while (lower_slot(x) < n_pts && pts_x[lower_slot(x)] == x)
			x = $urandom;
		send_request(plit_pkg::REQ_LOAD, x, $urandom);
		send_request(plit_pkg::REQ_LOAD, pts_x[0], $urandom);
		send_request(plit_pkg::REQ_LOAD, pts_x[DEPTH-1], 32'sh8000_0000);
		send_request(plit_pkg::REQ_QUERY, x, 32'sd0);
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = plit_pkg::REQ_NONE;
		key_x = '0;
		operand_y = '0;
		hold_req = 1'b0;
		errors = 0;
		n_pts = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_lookup();
		test_backpressure();
		test_random(1200);
		test_full_table();

		@(negedge clk);
		in_valid = 1'b0;
		wait_cycles = 0;
		while (answers_due.size() > 0 && wait_cycles < IDLE_LIMIT * 4) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0)
			$display("[piecewise_linear_interp_table] OK");
		else
			$display("[piecewise_linear_interp_table] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/plit_pkg.sv
rtl/core/plit_cell.sv
rtl/core/plit_div.sv
rtl/core/piecewise_linear_interp_table.sv
sim/testbench.sv
